// ----- rtl/core/bfla_pkg.sv -----
// bfla_pkg: shared types and constants of the block free list allocator
// operation and status codes, field widths, register indexes and reset values
// depends on nothing
package bfla_pkg;

  // field widths
  localparam int ID_W    = 10;
  localparam int ADDR_W  = 48;
  localparam int BSIZE_W = 32;
  localparam int NBLK_W  = 11;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 48;
  localparam int CIDX_W  = 2;

  // default pool depth
  localparam int DEF_MAX_BLOCKS = 1024;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_POOL_BLOCKS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_POOL_BASE   = 2'd2;

  // register reset values
  localparam logic [NBLK_W-1:0]  RST_POOL_BLOCKS = 11'd1024;
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE  = 32'd4096;
  localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = 48'd0;

  // shift control handed along the stack chain
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// ----- rtl/core/block_free_list_allocator.sv -----
// block_free_list_allocator: top level of the block free list allocator
// pops, pushes and translates block ids; holds the configuration registers
// depends on bfla_pkg and bfla_stack
//
// Use: items enter on the s_ channel; s_tuser carries the operation (allocate,
// free, translate) and s_tdata the block id. Every item gives exactly one
// result item on the m_ channel: granted id and address in m_tdata, status in
// m_tuser. A result appears in the cycle after its item is accepted, held
// in an output register; one item is taken per cycle as long as the receiver
// keeps up. When the receiver stalls, the output register holds its result
// and s_tready drops until it is taken; a new item is accepted in the same
// cycle as the pending result leaves.
// The free list is a fresh-id counter under a stack of freed ids; the
// stack is a chain of MAX_BLOCKS cells that shift by one place on each
// push or pop. Translate is one 10 x 32 multiply and one 48-bit add
// before the output register.
// Reset (rst, synchronous) restores a pool of 1024 blocks, block_size 4096
// and pool_base 0 and refills the list at once; no clearing pass is needed, as
// a stack cell is read only after it has been pushed. Writing the pool size
// register on the configuration port refills the list in the same way.
module block_free_list_allocator #(
  parameter int MAX_BLOCKS = bfla_pkg::DEF_MAX_BLOCKS
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // [9:0] blk_id, rest zero
  input  logic [bfla_pkg::FUNC_W-1:0]  s_tuser,   // [1:0] func
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [63:0]                  m_tdata,   // [9:0] granted_id, [57:10] address
  output logic [bfla_pkg::STAT_W-1:0]  m_tuser,   // [1:0] status
  // configuration writes
  input  logic                         cfg_we,
  input  logic [bfla_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bfla_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > bfla_pkg::NBLK_W) ? CNT_W : bfla_pkg::NBLK_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BLOCKS);
  localparam int PROD_W = bfla_pkg::ID_W + bfla_pkg::BSIZE_W;

  // configuration registers
  logic [bfla_pkg::NBLK_W-1:0]  pool_blocks;
  logic [bfla_pkg::BSIZE_W-1:0] block_size;
  logic [bfla_pkg::ADDR_W-1:0]  pool_base;

  // free list state
  logic [CNT_W-1:0] stack_count, stack_count_next;
  logic [CNT_W-1:0] fresh_next, fresh_next_next;

  // output register
  logic [bfla_pkg::ID_W-1:0]   out_id, out_id_next;
  logic [bfla_pkg::ADDR_W-1:0] out_addr, out_addr_next;
  logic [bfla_pkg::STAT_W-1:0] out_stat, out_stat_next;

  logic                       s_accept;
  logic [bfla_pkg::ID_W-1:0]  in_id;
  logic [bfla_pkg::ID_W-1:0]  top_id;
  bfla_pkg::shift_t           stack_ctl;
  logic [CMP_W-1:0]           pool_n;
  logic [CMP_W-1:0]           nblk_ext;
  logic [CMP_W-1:0]           fresh_ext;
  logic [CMP_W-1:0]           id_ext;
  logic                       list_full;
  logic [PROD_W-1:0]          product;

  assign in_id    = s_tdata[bfla_pkg::ID_W-1:0];
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // effective pool size, capped at the stack depth
  assign nblk_ext  = CMP_W'(pool_blocks);
  assign pool_n    = (nblk_ext > MAX_CMP) ? MAX_CMP : nblk_ext;
  assign fresh_ext = CMP_W'(fresh_next);
  assign id_ext    = CMP_W'(in_id);
  assign list_full = (stack_count >= fresh_next) || (stack_count >= CNT_W'(MAX_BLOCKS));
  assign product   = PROD_W'(in_id) * PROD_W'(block_size);

  // operation decode and result
  always_comb begin
    stack_count_next = stack_count;
    fresh_next_next  = fresh_next;
    stack_ctl        = '0;
    out_id_next      = '0;
    out_addr_next    = '0;
    out_stat_next    = bfla_pkg::STAT_OK;
    case (s_tuser)
      bfla_pkg::FUNC_ALLOC: begin
        if (stack_count != '0) begin
          stack_count_next = stack_count - CNT_W'(1);
          stack_ctl.pop    = s_accept;
          out_id_next      = top_id;
        end else if (fresh_ext < pool_n) begin
          fresh_next_next = fresh_next + CNT_W'(1);
          out_id_next     = bfla_pkg::ID_W'(fresh_next);
        end else begin
          out_stat_next = bfla_pkg::STAT_EMPTY;
        end
      end
      bfla_pkg::FUNC_FREE: begin
        if (list_full) begin
          out_stat_next = bfla_pkg::STAT_FULL;
        end else begin
          stack_count_next = stack_count + CNT_W'(1);
          stack_ctl.push   = s_accept;
        end
      end
      bfla_pkg::FUNC_TRANSLATE: begin
        if (id_ext < pool_n) begin
          out_addr_next = pool_base + bfla_pkg::ADDR_W'(product);
        end else begin
          out_stat_next = bfla_pkg::STAT_RANGE;
        end
      end
      default: begin
        out_stat_next = bfla_pkg::STAT_OK;
      end
    endcase
  end

  // freed-id stack
  bfla_stack #(
    .DEPTH (MAX_BLOCKS)
  ) u_stack (
    .clk     (clk),
    .ctl     (stack_ctl),
    .push_id (in_id),
    .top_id  (top_id)
  );

  // configuration registers and list counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_blocks <= bfla_pkg::RST_POOL_BLOCKS;
      block_size  <= bfla_pkg::RST_BLOCK_SIZE;
      pool_base   <= bfla_pkg::RST_POOL_BASE;
      stack_count <= '0;
      fresh_next  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfla_pkg::REG_POOL_BLOCKS: begin
          pool_blocks <= cfg_data[bfla_pkg::NBLK_W-1:0];
          stack_count <= '0;
          fresh_next  <= '0;
        end
        bfla_pkg::REG_BLOCK_SIZE: begin
          block_size <= cfg_data[bfla_pkg::BSIZE_W-1:0];
        end
        bfla_pkg::REG_POOL_BASE: begin
          pool_base <= cfg_data;
        end
        default: begin
          pool_blocks <= pool_blocks;
        end
      endcase
    end else if (s_accept) begin
      stack_count <= stack_count_next;
      fresh_next  <= fresh_next_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_id   <= out_id_next;
      out_addr <= out_addr_next;
      out_stat <= out_stat_next;
    end
  end

  assign m_tdata = {6'd0, out_addr, out_id};
  assign m_tuser = out_stat;

  // the freed stack never holds more ids than have been handed out
  a_count_le_fresh: assert property (@(posedge clk) disable iff (rst)
    stack_count <= fresh_next)
    else $error("freed stack deeper than ids handed out");

  // fresh counter stays within the stack depth
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= CNT_W'(MAX_BLOCKS))
    else $error("fresh id counter beyond pool depth");

  // an accepted item always leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> m_tvalid)
    else $error("accepted item gave no result");

  // a push that is not dropped deepens the stack by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !cfg_we && stack_ctl.push) |=> (stack_count == $past(stack_count) + CNT_W'(1)))
    else $error("push did not deepen the freed stack");

endmodule

// ----- rtl/core/bfla_cell.sv -----
// bfla_cell: one entry of the freed-id stack chain
// takes the entry above on a push and the entry below on a pop
// depends on bfla_pkg
module bfla_cell (
  input  logic                      clk,
  input  bfla_pkg::shift_t          ctl,
  input  logic [bfla_pkg::ID_W-1:0] up_id,
  input  logic [bfla_pkg::ID_W-1:0] down_id,
  output logic [bfla_pkg::ID_W-1:0] id
);

  // shift towards the bottom on push, towards the top on pop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      id <= up_id;
    end else if (ctl.pop) begin
      id <= down_id;
    end
  end

endmodule

// ----- rtl/core/bfla_stack.sv -----
// bfla_stack: freed-id stack built as a chain of shifting cells
// the top of the stack is always cell 0
// depends on bfla_pkg and bfla_cell
module bfla_stack #(
  parameter int DEPTH = bfla_pkg::DEF_MAX_BLOCKS
) (
  input  logic                      clk,
  input  bfla_pkg::shift_t          ctl,
  input  logic [bfla_pkg::ID_W-1:0] push_id,
  output logic [bfla_pkg::ID_W-1:0] top_id
);

  logic [bfla_pkg::ID_W-1:0] cell_id [DEPTH];

  // row of cells, each linked to its two neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [bfla_pkg::ID_W-1:0] up_id;
    logic [bfla_pkg::ID_W-1:0] down_id;

    if (i == 0) begin : g_top
      assign up_id = push_id;
    end else begin : g_mid_up
      assign up_id = cell_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_id = '0;
    end else begin : g_mid_down
      assign down_id = cell_id[i+1];
    end

    bfla_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .up_id   (up_id),
      .down_id (down_id),
      .id      (cell_id[i])
    );
  end

  assign top_id = cell_id[0];

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for block_free_list_allocator
// keeps its own free list and address arithmetic to predict every result item
// depends on bfla_pkg and the block_free_list_allocator rtl
module testbench;

  // widths and codes taken from the package
  localparam int ID_W    = bfla_pkg::ID_W;
  localparam int ADDR_W  = bfla_pkg::ADDR_W;
  localparam int BSIZE_W = bfla_pkg::BSIZE_W;
  localparam int NBLK_W  = bfla_pkg::NBLK_W;
  localparam int FUNC_W  = bfla_pkg::FUNC_W;
  localparam int STAT_W  = bfla_pkg::STAT_W;
  localparam int CFG_W   = bfla_pkg::CFG_W;
  localparam int CIDX_W  = bfla_pkg::CIDX_W;

  localparam logic [FUNC_W-1:0]  FUNC_ALLOC      = bfla_pkg::FUNC_ALLOC;
  localparam logic [FUNC_W-1:0]  FUNC_FREE       = bfla_pkg::FUNC_FREE;
  localparam logic [FUNC_W-1:0]  FUNC_TRANSLATE  = bfla_pkg::FUNC_TRANSLATE;
  localparam logic [STAT_W-1:0]  STAT_OK         = bfla_pkg::STAT_OK;
  localparam logic [STAT_W-1:0]  STAT_EMPTY      = bfla_pkg::STAT_EMPTY;
  localparam logic [STAT_W-1:0]  STAT_FULL       = bfla_pkg::STAT_FULL;
  localparam logic [STAT_W-1:0]  STAT_RANGE      = bfla_pkg::STAT_RANGE;
  localparam logic [CIDX_W-1:0]  REG_POOL_BLOCKS = bfla_pkg::REG_POOL_BLOCKS;
  localparam logic [CIDX_W-1:0]  REG_BLOCK_SIZE  = bfla_pkg::REG_BLOCK_SIZE;
  localparam logic [CIDX_W-1:0]  REG_POOL_BASE   = bfla_pkg::REG_POOL_BASE;
  localparam logic [NBLK_W-1:0]  RST_POOL_BLOCKS = bfla_pkg::RST_POOL_BLOCKS;
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE  = bfla_pkg::RST_BLOCK_SIZE;
  localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = bfla_pkg::RST_POOL_BASE;

  localparam int CLK_PERIOD     = 8;
  localparam int POOL_MAX       = bfla_pkg::DEF_MAX_BLOCKS;
  localparam int FULL_POOL      = POOL_MAX / 2;
  localparam int IDLE_PCT       = 23;
  localparam int HOLD_CYCLES    = 64;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0]  ADDR_MAX    = {ADDR_W{1'b1}};
  localparam logic [BSIZE_W-1:0] BSIZE_MAX   = {BSIZE_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]   granted;
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
  } alloc_result_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata   = '0;
  logic [FUNC_W-1:0] s_tuser   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [63:0]       m_tdata;
  logic [STAT_W-1:0] m_tuser;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  // predicted state of the block
  logic [NBLK_W-1:0]  pool_blocks_reg = RST_POOL_BLOCKS;
  logic [BSIZE_W-1:0] block_size_reg  = RST_BLOCK_SIZE;
  logic [ADDR_W-1:0]  pool_base_reg   = RST_POOL_BASE;
  logic [ID_W-1:0]    freed_ids [POOL_MAX];
  int                 stack_depth = 0;
  int                 fresh_id    = 0;

  // ids handed out and not yet freed, used to build sensible frees
  logic [ID_W-1:0] held_ids [$];
  alloc_result_t   awaited_results [$];

  bit   no_idle = 1'b0;
  bit   holding = 1'b0;
  event start_hold;

  int err_count    = 0;
  int results_seen = 0;
  int items_sent   = 0;
  int reg_writes   = 0;
  int n_granted    = 0;
  int n_empty      = 0;
  int n_full       = 0;
  int n_range      = 0;
  int quiet_cycles = 0;

  block_free_list_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // effective pool size, the pool size register capped at the stack depth
  function automatic int pool_limit();
    return (pool_blocks_reg > POOL_MAX) ? POOL_MAX : int'(pool_blocks_reg);
  endfunction

  // advance the predicted free list by one operation
  task automatic free_list_step(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] id,
                                output alloc_result_t r);
    int          pool;
    logic [63:0] sum;
    pool = pool_limit();
    r = '0;
    case (op)
      FUNC_ALLOC: begin
        if (stack_depth > 0) begin
          stack_depth--;
          r.granted = freed_ids[stack_depth];
        end else if (fresh_id < pool) begin
          r.granted = fresh_id[ID_W-1:0];
          fresh_id++;
        end else begin
          r.status = STAT_EMPTY;
        end
        if (r.status == STAT_OK) begin
          held_ids.insert(held_ids.size(), r.granted);
          n_granted++;
        end else begin
          n_empty++;
        end
      end
      FUNC_FREE: begin
        // list full when every id handed out has come back
        if (stack_depth >= fresh_id) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          freed_ids[stack_depth] = id;
          stack_depth++;
        end
      end
      FUNC_TRANSLATE: begin
        if (id < pool) begin
          sum = {16'd0, pool_base_reg} + {32'd0, block_size_reg} * {54'd0, id};
          r.addr = sum[ADDR_W-1:0];
        end else begin
          r.status = STAT_RANGE;
          n_range++;
        end
      end
      default: ;
    endcase
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POOL_BLOCKS: begin
        pool_blocks_reg = value[NBLK_W-1:0];
        stack_depth = 0;
        fresh_id = 0;
        held_ids.delete();
      end
      REG_BLOCK_SIZE: block_size_reg = value[BSIZE_W-1:0];
      REG_POOL_BASE:  pool_base_reg = value[ADDR_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // offer one item, with random gaps, and predict it once taken
  task automatic send_item(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] id);
    alloc_result_t want;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(16 - ID_W){1'b0}}, id};
    do @(posedge clk); while (!s_tready);
    free_list_step(op, id, want);
    awaited_results.insert(awaited_results.size(), want);
    items_sent++;
  endtask

  // stop offering and wait for every awaited result
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // random operation, frees mostly return ids that were handed out
  task automatic send_random_item();
    logic [FUNC_W-1:0] op;
    logic [ID_W-1:0]   id;
    int                pick;
    int                k;
    int                pool;
    pool = pool_limit();
    pick = $urandom_range(99);
    id = ID_W'($urandom_range(POOL_MAX - 1));
    if (pick < 42) begin
      op = FUNC_ALLOC;
    end else if (pick < 77) begin
      op = FUNC_FREE;
      if (held_ids.size() > 0 && $urandom_range(99) < 80) begin
        k = $urandom_range(held_ids.size() - 1);
        id = held_ids[k];
        held_ids.delete(k);
      end
    end else if (pick < 95) begin
      op = FUNC_TRANSLATE;
      if (pool > 0 && $urandom_range(99) < 70) id = ID_W'($urandom_range(pool - 1));
    end else begin
      op = FUNC_UNUSED;
    end
    send_item(op, id);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    err_count++;
    if (err_count <= REPORT_LIMIT)
      $display("%0t result %0d %s: expected 0x%0h, got 0x%0h",
               $time, results_seen, what, want, got);
  endtask

  // defaults after reset: fresh ids, translates, frees of any id, full drop, unused op
  task automatic test_reset_state();
    send_item(FUNC_ALLOC, 10'h3ff);
    send_item(FUNC_ALLOC, 10'h000);
    send_item(FUNC_TRANSLATE, 10'h3ff);
    send_item(FUNC_TRANSLATE, 10'd1);
    send_item(FUNC_FREE, 10'h3ff);
    send_item(FUNC_ALLOC, 10'd0);
    send_item(FUNC_FREE, 10'd0);
    send_item(FUNC_FREE, 10'd5);
    send_item(FUNC_FREE, 10'd7);
    send_item(FUNC_ALLOC, 10'd0);
    send_item(FUNC_UNUSED, 10'h3ff);
    wait_idle();
  endtask

  // single block pool, empty pool, oversized pool, address wrap and zero block size
  task automatic test_register_extremes();
    write_reg(REG_POOL_BLOCKS, 48'd1);
    send_item(FUNC_ALLOC, 10'd0);
    send_item(FUNC_ALLOC, 10'd0);
    send_item(FUNC_TRANSLATE, 10'd1);
    send_item(FUNC_TRANSLATE, 10'd0);
    send_item(FUNC_FREE, 10'h3ff);
    send_item(FUNC_FREE, 10'd0);
    wait_idle();
    write_reg(REG_POOL_BLOCKS, 48'd0);
    send_item(FUNC_ALLOC, 10'd0);
    send_item(FUNC_FREE, 10'd0);
    send_item(FUNC_TRANSLATE, 10'd0);
    wait_idle();
    write_reg(REG_POOL_BLOCKS, 48'd2047);
    write_reg(REG_BLOCK_SIZE, {16'd0, BSIZE_MAX});
    write_reg(REG_POOL_BASE, ADDR_MAX);
    send_item(FUNC_TRANSLATE, 10'h3ff);
    send_item(FUNC_TRANSLATE, 10'd0);
    wait_idle();
    write_reg(REG_BLOCK_SIZE, 48'd0);
    send_item(FUNC_TRANSLATE, 10'd512);
    wait_idle();
  endtask

  // drain all fresh ids, fill the whole free list, then pop it back out
  task automatic test_full_stack();
    write_reg(REG_POOL_BLOCKS, CFG_W'(FULL_POOL));
    write_reg(REG_BLOCK_SIZE, 48'd1);
    write_reg(REG_POOL_BASE, {16'($urandom()), $urandom()});
    repeat (FULL_POOL + 1) send_item(FUNC_ALLOC, ID_W'($urandom_range(POOL_MAX - 1)));
    repeat (FULL_POOL + 1) send_item(FUNC_FREE, ID_W'($urandom_range(POOL_MAX - 1)));
    send_item(FUNC_TRANSLATE, ID_W'($urandom_range(POOL_MAX - 1)));
    repeat (FULL_POOL + 1) send_item(FUNC_ALLOC, ID_W'($urandom_range(POOL_MAX - 1)));
    wait_idle();
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    no_idle = 1'b1;
    -> start_hold;
    repeat (24) send_random_item();
    wait_idle();
    no_idle = 1'b0;
  endtask

  // random phases over many register settings, one phase without idling
  task automatic test_random_mix();
    logic [CFG_W-1:0] nb;
    logic [CFG_W-1:0] bs;
    logic [CFG_W-1:0] base;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(7))
        0:       nb = CFG_W'(1);
        1:       nb = CFG_W'(2);
        2, 3:    nb = CFG_W'($urandom_range(16, 3));
        4:       nb = CFG_W'($urandom_range(1024, 17));
        5:       nb = CFG_W'(POOL_MAX);
        6:       nb = CFG_W'($urandom_range(2047, 1025));
        default: nb = '0;
      endcase
      case ($urandom_range(4))
        0:       bs = CFG_W'(1);
        1:       bs = {16'd0, BSIZE_MAX};
        2:       bs = CFG_W'(4096);
        default: bs = {16'd0, $urandom()};
      endcase
      case ($urandom_range(3))
        0:       base = '0;
        1:       base = ADDR_MAX;
        default: base = {16'($urandom()), $urandom()};
      endcase
      // some phases keep the list as it stands across the address writes
      if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_POOL_BLOCKS, nb);
      write_reg(REG_BLOCK_SIZE, bs);
      write_reg(REG_POOL_BASE, base);
      no_idle = (phase == 5);
      repeat ((phase == 5) ? 150 : 30) send_random_item();
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  // receiver ready, random idling unless held off or in a steady stretch
  always @(negedge clk) begin
    if (holding)
      m_tready <= 1'b0;
    else if (no_idle)
      m_tready <= 1'b1;
    else
      m_tready <= ($urandom_range(99) >= IDLE_PCT);
  end

  // long receiver hold-off, counted here
  always begin
    @(start_hold);
    @(posedge clk);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result", 64'd0, {m_tuser, m_tdata[61:0]});
      end else begin
        want = awaited_results.pop_front();
        if (m_tdata[ID_W-1:0] !== want.granted)
          note_mismatch("granted_id", 64'(want.granted), 64'(m_tdata[ID_W-1:0]));
        if (m_tdata[ID_W +: ADDR_W] !== want.addr)
          note_mismatch("address", 64'(want.addr), 64'(m_tdata[ID_W +: ADDR_W]));
        if (m_tuser !== want.status)
          note_mismatch("status", 64'(want.status), 64'(m_tuser));
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding",
               quiet_cycles, awaited_results.size());
      $display("block_free_list_allocator test failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_extremes();
    test_full_stack();
    test_backpressure();
    test_random_mix();
    $display("%0d items over %0d register writes: %0d ids granted, %0d empty,",
             items_sent, reg_writes, n_granted, n_empty);
    $display("%0d full drops, %0d out of range; %0d results checked, %0d mismatches",
             n_full, n_range, results_seen, err_count);
    if (err_count == 0 && awaited_results.size() == 0)
      $display("block_free_list_allocator test passed");
    else
      $display("block_free_list_allocator test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bfla_pkg.sv
rtl/core/bfla_cell.sv
rtl/core/bfla_stack.sv
rtl/core/block_free_list_allocator.sv
tb/testbench.sv
